// ===== hw/rtl/rtcc_pkg.sv =====
// Package: payload types, command codes and calendar constants for the RTC converter.
package rtcc_pkg;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] in_year;
    logic [3:0]  in_month;
    logic [4:0]  in_day;
    logic [4:0]  in_hour;
    logic [5:0]  in_minute;
    logic [5:0]  in_second;
    logic [31:0] in_seconds_count;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [2:0]  out_weekday;
    logic [31:0] out_seconds_count;
    logic        bad_date;
  } out_item_t;

  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_SET    = 3'd1;
  localparam logic [2:0] CMD_READ   = 3'd2;
  localparam logic [2:0] CMD_ENCODE = 3'd3;
  localparam logic [2:0] CMD_DECODE = 3'd4;

  localparam logic [31:0] BASE        = 32'd946656000;
  localparam logic [31:0] TZ_OFFSET   = 32'd28800;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;
  localparam logic [10:0] DAYS4       = 11'd1461;
  localparam logic [11:0] YEAR0       = 12'd2000;

  // Queued work for the back end.
  typedef struct packed {
    logic        encode;      // run date to seconds first
    logic        result_only; // command 3: keep encoded value, no date
    logic        keep_clock;  // command 4: report clock, decode input
    logic        set_clock;   // command 1
    logic        tick;        // command 0
    logic        bad;
    in_item_t    item;
  } job_t;

  function automatic logic [10:0] cum_days(input logic [5:0] idx);
    logic [10:0] r;
    case (idx)
      6'd0: r = 11'd0;     6'd1: r = 11'd31;    6'd2: r = 11'd60;    6'd3: r = 11'd91;
      6'd4: r = 11'd121;   6'd5: r = 11'd152;   6'd6: r = 11'd182;   6'd7: r = 11'd213;
      6'd8: r = 11'd244;   6'd9: r = 11'd274;   6'd10: r = 11'd305;  6'd11: r = 11'd335;
      6'd12: r = 11'd366;  6'd13: r = 11'd397;  6'd14: r = 11'd425;  6'd15: r = 11'd456;
      6'd16: r = 11'd486;  6'd17: r = 11'd517;  6'd18: r = 11'd547;  6'd19: r = 11'd578;
      6'd20: r = 11'd609;  6'd21: r = 11'd639;  6'd22: r = 11'd670;  6'd23: r = 11'd700;
      6'd24: r = 11'd731;  6'd25: r = 11'd762;  6'd26: r = 11'd790;  6'd27: r = 11'd821;
      6'd28: r = 11'd851;  6'd29: r = 11'd882;  6'd30: r = 11'd912;  6'd31: r = 11'd943;
      6'd32: r = 11'd974;  6'd33: r = 11'd1004; 6'd34: r = 11'd1035; 6'd35: r = 11'd1065;
      6'd36: r = 11'd1096; 6'd37: r = 11'd1127; 6'd38: r = 11'd1155; 6'd39: r = 11'd1186;
      6'd40: r = 11'd1216; 6'd41: r = 11'd1247; 6'd42: r = 11'd1277; 6'd43: r = 11'd1308;
      6'd44: r = 11'd1339; 6'd45: r = 11'd1369; 6'd46: r = 11'd1400; 6'd47: r = 11'd1430;
      default: r = 11'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/rtcc_front.sv =====
// Front end: accepts commands, classifies them and checks the date.
module rtcc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rtcc_pkg::in_item_t in_data,
  output logic              job_valid,
  input  logic              job_stall,
  output rtcc_pkg::job_t    job
);
  import rtcc_pkg::*;

  logic bad;
  assign in_stall = job_valid && job_stall;
  assign bad = (in_data.in_month == 4'd0) || (in_data.in_month > 4'd12) ||
               (in_data.in_day == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      job.item        <= in_data;
      job.tick        <= in_data.cmd == CMD_TICK;
      job.set_clock   <= in_data.cmd == CMD_SET;
      job.encode      <= in_data.cmd == CMD_SET || in_data.cmd == CMD_ENCODE;
      job.result_only <= in_data.cmd == CMD_ENCODE;
      job.keep_clock  <= in_data.cmd == CMD_DECODE;
      job.bad         <= (in_data.cmd == CMD_SET || in_data.cmd == CMD_ENCODE) && bad;
    end
  end
endmodule

// ===== hw/rtl/rtcc_queue.sv =====
// Two-entry queue between the front and back ends.
module rtcc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  rtcc_pkg::job_t wr_data,
  output logic           rd_valid,
  input  logic           rd_stall,
  output rtcc_pkg::job_t rd_data
);
  import rtcc_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign wr_stall = count == 2'd2;
  assign rd_valid = count != 2'd0;
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem[wp] <= wr_data;
  end
endmodule

// ===== hw/rtl/rtcc_back.sv =====
// Back end: clock state, date encoding and iterative decoding.
module rtcc_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  output logic                job_stall,
  input  rtcc_pkg::job_t      job,
  input  logic [7:0]          ticks_per_second,
  output logic                out_valid,
  input  logic                out_stall,
  output rtcc_pkg::out_item_t out_data
);
  import rtcc_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ENC1 = 8'b0000_0010,
    S_ENC2 = 8'b0000_0100,
    S_APPLY = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_YEAR = 8'b0010_0000,
    S_MON  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t state;
  job_t cur;
  logic [31:0] clock_seconds;
  logic [7:0] tick_phase;
  logic [31:0] enc, dec_src, secs_e, acc;
  logic [31:0] days_part, hms_part;
  logic [5:0] digit_sec, digit_min;
  logic [4:0] digit_hour;
  logic [3:0] phase;
  logic [5:0] quad;
  logic [10:0] dinq;
  logic [1:0] yy;
  logic [3:0] mm;
  logic [2:0] wday;
  logic [5:0] idx;
  logic [11:0] yo;
  logic        div5;
  logic [63:0] prod;
  logic [31:0] div_q;
  logic [32:0] quad_prod;
  logic [16:0] wk_x;
  logic [34:0] wk_prod;
  logic        load_out;

  assign job_stall = state != S_IDLE;
  assign yo = cur.item.in_year - YEAR0;
  assign idx = {yo[1:0], 4'd0} - {2'd0, yo[1:0], 2'd0} + {2'd0, cur.item.in_month - 4'd1};

  // reciprocal steps: divide by 3 or by 5
  assign div5 = phase inside {4'd2, 4'd5, 4'd13, 4'd14};
  assign prod = {32'd0, acc} * {32'd0, (div5 ? 32'hCCCC_CCCD : 32'hAAAA_AAAB)};
  assign div_q = div5 ? {2'd0, prod[63:34]} : {1'b0, prod[63:33]};
  assign quad_prod = {17'd0, acc[15:0]} * 33'd91868;
  assign wk_x = acc[16:0] + 17'd4;
  assign wk_prod = {18'd0, wk_x} * 35'd149797;
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clock_seconds <= 32'd0;
      tick_phase <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (job_valid) begin
          cur <= job;
          state <= job.encode ? S_ENC1 : S_APPLY;
        end
        S_ENC1: begin
          days_part <= ({22'd0, yo[11:2]} * 32'(DAYS4) + 32'(cum_days(idx))
                       + 32'(cur.item.in_day) - 32'd1);
          hms_part <= 32'(cur.item.in_hour) * 32'd3600 + 32'(cur.item.in_minute) * 32'd60
                      + 32'(cur.item.in_second);
          state <= S_ENC2;
        end
        S_ENC2: begin
          enc <= (cur.bad || cur.item.in_year < YEAR0) ? 32'd0 :
                 days_part * 32'(SEC_PER_DAY) + hms_part + BASE;
          state <= S_APPLY;
        end
        S_APPLY: begin
          if (cur.set_clock) begin
            clock_seconds <= enc;
            dec_src <= enc;
          end else if (cur.result_only) begin
            dec_src <= enc;
          end else if (cur.keep_clock) begin
            dec_src <= cur.item.in_seconds_count;
          end else if (cur.tick && clock_seconds >= BASE &&
                       tick_phase + 8'd1 >= ticks_per_second) begin
            tick_phase <= 8'd0;
            clock_seconds <= clock_seconds + 32'd1;
            dec_src <= clock_seconds + 32'd1;
          end else begin
            if (cur.tick && clock_seconds >= BASE) tick_phase <= tick_phase + 8'd1;
            dec_src <= clock_seconds;
          end
          phase <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          // Constant division by reciprocal multiplication, one step per cycle:
          // seconds, minutes, hours, four-year blocks, then the weekday.
          case (phase)
            4'd0: begin
              secs_e <= dec_src - BASE;
              acc <= (dec_src - BASE) >> 2;
            end
            4'd3: begin
              digit_sec <= 6'(secs_e - acc * 32'd60);
              secs_e <= acc;
              acc <= acc >> 2;
            end
            4'd6: begin
              digit_min <= 6'(secs_e - acc * 32'd60);
              secs_e <= acc;
              acc <= acc >> 3;
            end
            4'd8: begin
              digit_hour <= 5'(secs_e - acc * 32'd24);
              secs_e <= acc;
              quad <= quad_prod[32:27];
            end
            4'd9: begin
              dinq <= 11'(secs_e - {26'd0, quad} * 32'd1461);
              acc <= 32'((33'(dec_src) + 33'(TZ_OFFSET)) >> 7);
            end
            4'd15: begin
              wday <= 3'(wk_x - {2'd0, wk_prod[34:20]} * 17'd7);
              yy <= 2'd3;
              state <= S_YEAR;
            end
            default: acc <= div_q;
          endcase
          phase <= phase + 4'd1;
        end
        S_YEAR: begin
          if (yy != 2'd0 && dinq < cum_days({yy, 4'd0} - {2'd0, yy, 2'd0})) begin
            yy <= yy - 2'd1;
          end else begin
            mm <= 4'd11;
            state <= S_MON;
          end
        end
        S_MON: begin
          if (mm != 4'd0 &&
              dinq < cum_days({yy, 4'd0} - {2'd0, yy, 2'd0} + {2'd0, mm})) begin
            mm <= mm - 4'd1;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: if (load_out) begin
          if (dec_src < BASE || cur.result_only) begin
            out_data.out_year <= 12'd0;
            out_data.out_month <= 4'd0;
            out_data.out_day <= 5'd0;
            out_data.out_hour <= 5'd0;
            out_data.out_minute <= 6'd0;
            out_data.out_second <= 6'd0;
          end else begin
            out_data.out_year <= YEAR0 + 12'({quad, 2'd0}) + 12'(yy);
            out_data.out_month <= mm + 4'd1;
            out_data.out_day <= 5'(dinq - cum_days({yy, 4'd0} - {2'd0, yy, 2'd0}
                                + {2'd0, mm}) + 11'd1);
            out_data.out_hour <= digit_hour;
            out_data.out_minute <= digit_min;
            out_data.out_second <= digit_sec;
          end
          out_data.out_weekday <= (wday == 3'd0) ? 3'd7 : wday;
          out_data.out_seconds_count <= cur.result_only ? enc : clock_seconds;
          out_data.bad_date <= cur.bad;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/rtc_seconds_calendar_converter_unit.sv =====
// Top level of the RTC seconds and calendar converter.
// channel | direction | payload
// in      | input     | rtcc_pkg::in_item_t
// out     | output    | rtcc_pkg::out_item_t
// cfg     | input     | ticks_per_second, write only
// An item passes from input transfer to result through the front register
// and queue, encode (commands 1 and 3 only), apply, the reciprocal division
// steps, year search, month search and output load. Reset clears clock,
// prescaler and queue; ticks_per_second resets to 5. The front end and a
// two-entry queue keep taking items while the back end or the output stalls,
// until the queue is full; a stalled output holds the back end in its last state.
module rtc_seconds_calendar_converter_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  rtcc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rtcc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import rtcc_pkg::*;

  logic [7:0] ticks_per_second;
  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  always_ff @(posedge clk) begin
    if (rst) ticks_per_second <= 8'd5;
    else if (cfg_we) ticks_per_second <= cfg_wdata;
  end

  rtcc_front u_front (.clk, .rst, .in_valid, .in_stall, .in_data,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job));
  rtcc_queue u_queue (.clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_job));
  rtcc_back u_back (.clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .ticks_per_second, .out_valid, .out_stall, .out_data);
endmodule
